FILE: rtl/core/ebq_pkg.sv
package ebq_pkg;

  // default number of fed button slots
  localparam int BUTTON_COUNT_DEF = 4;
  // physical button slots on the port, plus one encoder switch slot
  localparam int NUM_BUTTONS = 4;
  localparam int NUM_SLOTS   = 5;

  // port bit positions
  localparam int BIT_ENC_CLK = 4;
  localparam int BIT_ENC_DT  = 5;
  localparam int BIT_SWITCH  = 6;

  // configuration register indexes
  localparam logic [7:0] REG_DEBOUNCE = 8'd0;
  localparam logic [7:0] REG_TIMEOUT  = 8'd1;

  // configuration reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd30;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  // decoder phase codes
  localparam logic [2:0] PH_REST   = 3'd0;
  localparam logic [2:0] PH_CW1    = 3'd1;
  localparam logic [2:0] PH_CW2    = 3'd2;
  localparam logic [2:0] PH_CW3    = 3'd3;
  localparam logic [2:0] PH_CCW1   = 3'd4;
  localparam logic [2:0] PH_CCW2   = 3'd5;
  localparam logic [2:0] PH_CCW3   = 3'd6;
  localparam logic [2:0] PH_UNUSED = 3'd7;

  // encoder input pair codes, {clk, dt}
  localparam logic [1:0] AB_00 = 2'd0;
  localparam logic [1:0] AB_01 = 2'd1;
  localparam logic [1:0] AB_10 = 2'd2;
  localparam logic [1:0] AB_11 = 2'd3;

  // step codes
  localparam logic signed [1:0] STEP_NONE    = 2'sb00;
  localparam logic signed [1:0] STEP_CW      = 2'sb01;
  localparam logic signed [1:0] STEP_CCW     = 2'sb11;
  localparam logic signed [1:0] STEP_ILLEGAL = 2'sb10;

  typedef struct packed {
    logic [7:0]  port_bits;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] encoder_step;
    logic [4:0]        press_events;
    logic [4:0]        held_buttons;
    logic [2:0]        encoder_phase;
  } out_item_t;

  // decoder result toward the output register
  typedef struct packed {
    logic signed [1:0] step;
    logic [2:0]        phase;
  } dec_res_t;

  // debouncer result toward the output register
  typedef struct packed {
    logic press;
    logic held;
  } deb_res_t;

endpackage

FILE: rtl/core/ebq_decoder.sv
module ebq_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [1:0]            ab,
  input  logic [31:0]           now_ms,
  input  logic [15:0]           timeout_ms,
  output ebq_pkg::dec_res_t     res
);

  logic [2:0]        phase_r;
  logic [2:0]        phase_nxt;
  logic [31:0]       change_time_r;
  logic [31:0]       change_time_nxt;
  logic [2:0]        trans;
  logic signed [1:0] step;
  logic              changed;
  logic              timed_out;

  // full-cycle transition table
  always_comb begin
    trans = phase_r;
    step  = ebq_pkg::STEP_NONE;
    case (phase_r)
      ebq_pkg::PH_CW1: begin
        if (ab == ebq_pkg::AB_00) trans = ebq_pkg::PH_CW2;
        else if (ab == ebq_pkg::AB_11) trans = ebq_pkg::PH_REST;
      end
      ebq_pkg::PH_CW2: begin
        if (ab == ebq_pkg::AB_10) trans = ebq_pkg::PH_CW3;
        else if (ab == ebq_pkg::AB_01) trans = ebq_pkg::PH_CW1;
      end
      ebq_pkg::PH_CW3: begin
        if (ab == ebq_pkg::AB_11) begin
          trans = ebq_pkg::PH_REST;
          step  = ebq_pkg::STEP_CW;
        end else if (ab == ebq_pkg::AB_00) begin
          trans = ebq_pkg::PH_CW2;
        end
      end
      ebq_pkg::PH_CCW1: begin
        if (ab == ebq_pkg::AB_00) trans = ebq_pkg::PH_CCW2;
        else if (ab == ebq_pkg::AB_11) trans = ebq_pkg::PH_REST;
      end
      ebq_pkg::PH_CCW2: begin
        if (ab == ebq_pkg::AB_01) trans = ebq_pkg::PH_CCW3;
        else if (ab == ebq_pkg::AB_10) trans = ebq_pkg::PH_CCW1;
      end
      ebq_pkg::PH_CCW3: begin
        if (ab == ebq_pkg::AB_11) begin
          trans = ebq_pkg::PH_REST;
          step  = ebq_pkg::STEP_CCW;
        end else if (ab == ebq_pkg::AB_00) begin
          trans = ebq_pkg::PH_CCW2;
        end
      end
      default: begin
        // rest, and the unused code which behaves as rest
        if (ab == ebq_pkg::AB_01) trans = ebq_pkg::PH_CW1;
        else if (ab == ebq_pkg::AB_10) trans = ebq_pkg::PH_CCW1;
        else trans = ebq_pkg::PH_REST;
      end
    endcase
  end

  // change stamp and idle timeout; a fresh change never times out
  always_comb begin
    changed   = (trans != phase_r) &&
                !(phase_r == ebq_pkg::PH_UNUSED && trans == ebq_pkg::PH_REST);
    timed_out = !changed && (trans != ebq_pkg::PH_REST) &&
                ((now_ms - change_time_r) > {16'd0, timeout_ms});
    change_time_nxt = changed ? now_ms : change_time_r;
    phase_nxt       = timed_out ? ebq_pkg::PH_REST : trans;
    res.step  = step;
    res.phase = phase_nxt;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ebq_pkg::PH_REST;
      change_time_r <= 32'd0;
    end else if (adv) begin
      phase_r       <= phase_nxt;
      change_time_r <= change_time_nxt;
    end
  end

endmodule

FILE: rtl/core/ebq_debouncer.sv
module ebq_debouncer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               active,
  input  logic [31:0]        now_ms,
  input  logic [15:0]        debounce_ms,
  output ebq_pkg::deb_res_t  res
);

  logic        last_r;
  logic        acc_r;
  logic        acc_nxt;
  logic [31:0] time_r;
  logic [31:0] time_nxt;
  logic        changed;
  logic        settled;

  // level tracking and acceptance after a stable interval
  always_comb begin
    changed  = (active != last_r);
    time_nxt = changed ? now_ms : time_r;
    settled  = !changed && ((now_ms - time_r) > {16'd0, debounce_ms});
    acc_nxt  = settled ? active : acc_r;
    res.press = settled && active && !acc_r;
    res.held  = acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
      acc_r  <= 1'b0;
      time_r <= 32'd0;
    end else if (adv) begin
      last_r <= active;
      acc_r  <= acc_nxt;
      time_r <= time_nxt;
    end
  end

endmodule

FILE: rtl/core/encoder_and_button_qualifier_unit.sv
// Encoder and button qualifier.
// Input channel in_valid/in_ready/in_item carries one active-low port sample
// with its millisecond timestamp. Result channel out_valid/out_ready/out_item
// gives exactly one result per item: encoder detent step, press events,
// debounced held levels and the decoder phase.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// debounce time (index 0) and encoder timeout (index 1); other indexes are
// dropped. cfg_ready is always high; write only while no item is in flight.
// An accepted item waits in the input register; its result is then written
// to the result register. Throughput: one item per cycle while the receiver
// keeps out_ready high; all per-item work is one short pass of 32-bit
// subtract-and-compare logic between the two registers.
// A stalled receiver holds the result register; the input register keeps
// taking one more item, then in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers, sets the decoder to
// rest, releases all debouncers, clears all time stamps to zero and loads
// the configuration defaults (30 ms debounce, 1000 ms timeout).
module encoder_and_button_qualifier_unit #(
  parameter int BUTTON_COUNT = ebq_pkg::BUTTON_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ebq_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ebq_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int FED = (BUTTON_COUNT > ebq_pkg::NUM_BUTTONS) ?
                       ebq_pkg::NUM_BUTTONS : BUTTON_COUNT;

  logic               in_valid_r;
  ebq_pkg::in_item_t  in_item_r;
  logic               out_valid_r;
  ebq_pkg::out_item_t out_item_r;
  logic [15:0]        debounce_r;
  logic [15:0]        timeout_r;
  logic               adv;
  ebq_pkg::dec_res_t  dec_res;
  ebq_pkg::deb_res_t  deb_res [ebq_pkg::NUM_SLOTS];
  logic [4:0]         press_vec;
  logic [4:0]         held_vec;

  // pipeline handshake
  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= ebq_pkg::DEBOUNCE_RST;
      timeout_r  <= ebq_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == ebq_pkg::REG_DEBOUNCE) debounce_r <= cfg_data;
      else if (cfg_index == ebq_pkg::REG_TIMEOUT) timeout_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_item_r <= in_item;
  end

  // quadrature decoder
  ebq_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .ab         ({in_item_r.port_bits[ebq_pkg::BIT_ENC_CLK],
                  in_item_r.port_bits[ebq_pkg::BIT_ENC_DT]}),
    .now_ms     (in_item_r.now_ms),
    .timeout_ms (timeout_r),
    .res        (dec_res)
  );

  // button debouncers; slots beyond the button count stay released
  for (genvar g = 0; g < ebq_pkg::NUM_BUTTONS; g++) begin : g_btn
    if (g < FED) begin : g_fed
      ebq_debouncer u_deb (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .active      (!in_item_r.port_bits[g]),
        .now_ms      (in_item_r.now_ms),
        .debounce_ms (debounce_r),
        .res         (deb_res[g])
      );
    end else begin : g_unfed
      assign deb_res[g] = '0;
    end
  end

  // encoder switch debouncer
  ebq_debouncer u_deb_sw (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .active      (!in_item_r.port_bits[ebq_pkg::BIT_SWITCH]),
    .now_ms      (in_item_r.now_ms),
    .debounce_ms (debounce_r),
    .res         (deb_res[ebq_pkg::NUM_SLOTS-1])
  );

  // gather slot results
  always_comb begin
    for (int i = 0; i < ebq_pkg::NUM_SLOTS; i++) begin
      press_vec[i] = deb_res[i].press;
      held_vec[i]  = deb_res[i].held;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.encoder_step  <= dec_res.step;
      out_item_r.press_events  <= press_vec;
      out_item_r.held_buttons  <= held_vec;
      out_item_r.encoder_phase <= dec_res.phase;
    end
  end

endmodule

FILE: rtl/core/ebq_checker.sv
module ebq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input ebq_pkg::out_item_t out_item
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result changed while stalled");

  // the step code is never the unused negative two
  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.encoder_step != ebq_pkg::STEP_ILLEGAL)
    else $error("illegal step code");

  // a completed detent leaves the decoder at rest
  a_step_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.encoder_step != ebq_pkg::STEP_NONE |->
    out_item.encoder_phase == ebq_pkg::PH_REST)
    else $error("detent without return to rest");

  // a press event implies the slot is now held
  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.press_events & ~out_item.held_buttons) == 5'd0)
    else $error("press event on a released slot");

endmodule

bind encoder_and_button_qualifier_unit ebq_checker u_ebq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam time HALF_PERIOD   = 4ns;
  localparam int  FED_BUTTONS   = ebq_pkg::BUTTON_COUNT_DEF;
  localparam int  RX_HOLD_CYCLES = 200;
  localparam int  MAX_REPORTED  = 10;
  localparam int  TAIL_CYCLES   = 4;

  // indexes past the register map, must be dropped by the block
  localparam logic [7:0] REG_SPARE = 8'd2;
  localparam logic [7:0] REG_TOP   = 8'hFF;

  // port levels for the directed part
  localparam logic [7:0] KEYS_UP   = 8'hFF;
  localparam logic [7:0] KEYS_DOWN = 8'h00;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ebq_pkg::in_item_t   in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ebq_pkg::out_item_t  out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  encoder_and_button_qualifier_unit #(
    .BUTTON_COUNT(FED_BUTTONS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // samples waiting to be sent, reports waiting to be seen
  ebq_pkg::in_item_t  sample_q[$];
  ebq_pkg::out_item_t report_q[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_start  = 1'b0;
  logic        rx_hold     = 1'b0;
  int          mismatches  = 0;
  int          reports_seen = 0;

  // mirror of the qualifier state and its registers
  logic [15:0] debounce_cfg = ebq_pkg::DEBOUNCE_RST;
  logic [15:0] timeout_cfg  = ebq_pkg::TIMEOUT_RST;
  logic [2:0]  dial_phase   = ebq_pkg::PH_REST;
  logic [31:0] phase_stamp  = '0;
  logic [ebq_pkg::NUM_SLOTS-1:0] last_act = '0;
  logic [ebq_pkg::NUM_SLOTS-1:0] held_lvl = '0;
  logic [31:0] act_stamp [ebq_pkg::NUM_SLOTS] = '{default: '0};

  // sample generator state
  logic [31:0] sim_now  = '0;
  logic [7:0]  key_bits = KEYS_UP;
  logic [1:0]  enc_ab   = ebq_pkg::AB_11;
  int unsigned span_hi  = 25;
  int          staged   = 0;

  // expected report for one accepted sample, advances the mirror
  function automatic ebq_pkg::out_item_t qualify_sample(ebq_pkg::in_item_t smp);
    ebq_pkg::out_item_t            res;
    logic [1:0]                    ab;
    logic [2:0]                    nxt;
    logic signed [1:0]             step;
    logic [ebq_pkg::NUM_SLOTS-1:0] act;
    logic [31:0]                   age;
    int                            s;
    res  = '0;
    step = ebq_pkg::STEP_NONE;
    ab   = {smp.port_bits[ebq_pkg::BIT_ENC_CLK], smp.port_bits[ebq_pkg::BIT_ENC_DT]};
    if (dial_phase > ebq_pkg::PH_CCW3) dial_phase = ebq_pkg::PH_REST;
    nxt = dial_phase;
    // full-cycle quadrature walk
    case (dial_phase)
      ebq_pkg::PH_CW1: begin
        if (ab == ebq_pkg::AB_00) nxt = ebq_pkg::PH_CW2;
        else if (ab == ebq_pkg::AB_11) nxt = ebq_pkg::PH_REST;
      end
      ebq_pkg::PH_CW2: begin
        if (ab == ebq_pkg::AB_10) nxt = ebq_pkg::PH_CW3;
        else if (ab == ebq_pkg::AB_01) nxt = ebq_pkg::PH_CW1;
      end
      ebq_pkg::PH_CW3: begin
        if (ab == ebq_pkg::AB_11) begin
          nxt  = ebq_pkg::PH_REST;
          step = ebq_pkg::STEP_CW;
        end else if (ab == ebq_pkg::AB_00) begin
          nxt = ebq_pkg::PH_CW2;
        end
      end
      ebq_pkg::PH_CCW1: begin
        if (ab == ebq_pkg::AB_00) nxt = ebq_pkg::PH_CCW2;
        else if (ab == ebq_pkg::AB_11) nxt = ebq_pkg::PH_REST;
      end
      ebq_pkg::PH_CCW2: begin
        if (ab == ebq_pkg::AB_01) nxt = ebq_pkg::PH_CCW3;
        else if (ab == ebq_pkg::AB_10) nxt = ebq_pkg::PH_CCW1;
      end
      ebq_pkg::PH_CCW3: begin
        if (ab == ebq_pkg::AB_11) begin
          nxt  = ebq_pkg::PH_REST;
          step = ebq_pkg::STEP_CCW;
        end else if (ab == ebq_pkg::AB_00) begin
          nxt = ebq_pkg::PH_CCW2;
        end
      end
      default: begin
        if (ab == ebq_pkg::AB_01) nxt = ebq_pkg::PH_CW1;
        else if (ab == ebq_pkg::AB_10) nxt = ebq_pkg::PH_CCW1;
      end
    endcase
    if (nxt != dial_phase) begin
      dial_phase  = nxt;
      phase_stamp = smp.now_ms;
    end
    // debouncers, active low on the port
    act = {~smp.port_bits[ebq_pkg::BIT_SWITCH], ~smp.port_bits[ebq_pkg::NUM_BUTTONS-1:0]};
    for (s = 0; s < ebq_pkg::NUM_SLOTS; s++) begin
      if (s < FED_BUTTONS || s == ebq_pkg::NUM_SLOTS - 1) begin
        if (act[s] != last_act[s]) begin
          last_act[s]  = act[s];
          act_stamp[s] = smp.now_ms;
        end
        age = smp.now_ms - act_stamp[s];
        if (age > {16'd0, debounce_cfg} && act[s] != held_lvl[s]) begin
          held_lvl[s] = act[s];
          res.press_events[s] = act[s];
        end
      end
    end
    // idle timeout, judged after the phase update
    age = smp.now_ms - phase_stamp;
    if (dial_phase != ebq_pkg::PH_REST && age > {16'd0, timeout_cfg})
      dial_phase = ebq_pkg::PH_REST;
    res.encoder_step  = step;
    res.held_buttons  = held_lvl;
    res.encoder_phase = dial_phase;
    return res;
  endfunction

  // sender: one item per handshake, random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) report_q.push_back(qualify_sample(in_item));
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_item  <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      if (mismatches < MAX_REPORTED)
        $display("report %0d: %s expected %0d, got %0d", reports_seen, field, want, got);
      mismatches++;
    end
  endtask

  // receiver: compare each report with the oldest expectation
  always @(posedge clk) begin : report_check
    ebq_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          if (mismatches < MAX_REPORTED)
            $display("report %0d: unexpected report %h", reports_seen, out_item);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("encoder_step", want.encoder_step, out_item.encoder_step);
          check_field("press_events", want.press_events, out_item.press_events);
          check_field("held_buttons", want.held_buttons, out_item.held_buttons);
          check_field("encoder_phase", want.encoder_phase, out_item.encoder_phase);
        end
        reports_seen++;
      end
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : rx_hold_off
    wait (hold_start);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic logic [7:0] port_of(logic [7:0] keys, logic [1:0] ab);
    logic [7:0] p;
    p = keys;
    p[ebq_pkg::BIT_ENC_CLK] = ab[1];
    p[ebq_pkg::BIT_ENC_DT]  = ab[0];
    return p;
  endfunction

  function automatic logic [1:0] turn_ab(int dir, int k);
    case (k)
      0:       return dir ? ebq_pkg::AB_10 : ebq_pkg::AB_01;
      1:       return ebq_pkg::AB_00;
      2:       return dir ? ebq_pkg::AB_01 : ebq_pkg::AB_10;
      default: return ebq_pkg::AB_11;
    endcase
  endfunction

  task automatic push_sample(input logic [7:0] port, input logic [31:0] stamp);
    ebq_pkg::in_item_t smp;
    smp.port_bits = port;
    smp.now_ms    = stamp;
    sample_q.push_back(smp);
    staged++;
  endtask

  // next sample: time moves on, a key may flip
  task automatic stage_sample(input logic [1:0] ab, input int churn_pct);
    int unsigned pick;
    if ($urandom_range(0, 99) < 2) sim_now = $urandom();
    else sim_now = sim_now + $urandom_range(0, span_hi);
    if ($urandom_range(0, 99) < churn_pct) begin
      pick = $urandom_range(0, 5);
      if (pick >= 4) pick = pick + 2;
      key_bits[pick] = ~key_bits[pick];
    end
    enc_ab = ab;
    push_sample(port_of(key_bits, ab), sim_now);
  endtask

  // mostly clean detents and key presses, some broken sequences and noise
  task automatic run_random(input int count);
    int goal;
    int sel;
    int len;
    int dir;
    int k;
    goal = staged + count;
    @(negedge clk);
    while (staged < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        dir = $urandom_range(0, 1);
        for (k = 0; k < 4; k++) begin
          stage_sample(turn_ab(dir, k), 3);
          // contact bounce back one phase and forward again
          if (k > 0 && k < 3 && $urandom_range(0, 4) == 0) begin
            stage_sample(turn_ab(dir, k - 1), 0);
            stage_sample(turn_ab(dir, k), 0);
          end
        end
      end else if (sel < 60) begin
        len = $urandom_range(1, 4);
        repeat (len) stage_sample(2'($urandom_range(0, 3)), 5);
      end else if (sel < 82) begin
        len = $urandom_range(2, 6);
        repeat (len) stage_sample(enc_ab, 70);
        len = $urandom_range(1, 3);
        repeat (len) stage_sample(enc_ab, 0);
      end else begin
        key_bits = 8'($urandom());
        stage_sample(2'($urandom_range(0, 3)), 0);
      end
    end
  endtask

  // wait until every item is sent and every report has come back
  task automatic settle();
    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ebq_pkg::REG_DEBOUNCE) debounce_cfg = val;
    else if (idx == ebq_pkg::REG_TIMEOUT) timeout_cfg = val;
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // run limit
  initial begin : watchdog
    #2_000_000ns;
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(36, 48);
    @(negedge clk);

    // idle port, then all keys down with bit 7 low
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_11), 32'd0);
    push_sample(port_of(KEYS_DOWN, ebq_pkg::AB_11), 32'd0);
    // debounce edge: equal to the limit is not enough, one more accepts
    push_sample(port_of(KEYS_DOWN, ebq_pkg::AB_11), 32'd30);
    push_sample(port_of(KEYS_DOWN, ebq_pkg::AB_11), 32'd31);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_11), 32'd40);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_11), 32'd71);
    // clockwise and counter-clockwise detents
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd100);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_00), 32'd101);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_10), 32'd102);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_11), 32'd103);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_10), 32'd110);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_00), 32'd111);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd112);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_11), 32'd113);
    // aborted turn back to rest
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd120);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_11), 32'd121);
    // step back within a turn, then timeout to rest
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd200);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_00), 32'd201);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd202);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd1202);
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd1203);
    // fresh move from rest at once, stamp renewed
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_01), 32'd1204);
    // unexpected pair holds the phase, huge gap times it out
    push_sample(port_of(KEYS_UP, ebq_pkg::AB_10), 32'hFFFF_FFFF);
    // clock wrap with every key down and the pair at zero
    push_sample(port_of(KEYS_DOWN, ebq_pkg::AB_00), 32'h0000_0010);
    sim_now  = 32'h0000_0010;
    key_bits = KEYS_DOWN;
    enc_ab   = ebq_pkg::AB_00;

    span_hi = 25;
    run_random(400);

    // shortest times, plus writes to unmapped indexes
    settle();
    write_reg(ebq_pkg::REG_DEBOUNCE, 16'd0);
    write_reg(ebq_pkg::REG_TIMEOUT, 16'd0);
    write_reg(REG_SPARE, 16'($urandom()));
    write_reg(REG_TOP, 16'hFFFF);
    span_hi = 2;
    run_random(250);

    // longest times, receiver stalls less than sender
    settle();
    set_idling(48, 36);
    write_reg(ebq_pkg::REG_DEBOUNCE, 16'hFFFF);
    write_reg(ebq_pkg::REG_TIMEOUT, 16'hFFFF);
    span_hi = 40000;
    run_random(300);

    settle();
    write_reg(ebq_pkg::REG_DEBOUNCE, 16'($urandom_range(1, 200)));
    write_reg(ebq_pkg::REG_TIMEOUT, 16'($urandom_range(1, 3000)));
    span_hi = 150;
    run_random(400);

    // no idling, long receiver hold-off at the start
    settle();
    set_idling(0, 0);
    write_reg(ebq_pkg::REG_DEBOUNCE, 16'd5);
    write_reg(ebq_pkg::REG_TIMEOUT, 16'd20);
    span_hi = 12;
    @(negedge clk);
    hold_start = 1'b1;
    run_random(350);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
